@@ src/rfr_pkg.sv @@
// Shared types, constants and functions for the Modbus RTU request frame receiver.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package rfr_pkg;

  localparam int FRAME_LENGTH = 8;
  localparam int POS_W        = 4;                          // holds 0..FRAME_LENGTH
  localparam int BYTE_IDX_W   = $clog2(FRAME_LENGTH - 1);   // indexes stored bytes

  localparam logic [POS_W-1:0] POS_IDLE   = '0;
  localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(FRAME_LENGTH - 2);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0] POS_DONE   = POS_W'(FRAME_LENGTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // word kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_SUPPORTED   = 2'd0;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
  localparam logic [1:0] STATUS_CRC_ERROR   = 2'd2;

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_SET    = 2'd2;

  // function codes
  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT     = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FC_WRITE_REGISTER = 8'd6;
  localparam logic [7:0] FC_DIAGNOSTICS    = 8'd8;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } rfr_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] function_code;
    logic [7:0] first_word_high;
    logic [7:0] first_word_low;
    logic [7:0] second_word_high;
    logic [7:0] second_word_low;
  } rfr_out_t;

  typedef struct packed {
    logic [7:0] station_id;
    logic [7:0] gap_ticks;
    logic       alt_function_set;
  } rfr_cfg_t;

  // CRC-16/MODBUS, one byte, bitwise reflected form
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // zero is treated as one tick
  function automatic logic [7:0] gap_reload(input logic [7:0] gap_ticks);
    return (gap_ticks == 8'd0) ? 8'd1 : gap_ticks;
  endfunction

  function automatic logic is_supported(input logic [7:0] code, input logic alt_set);
    logic ok;
    ok = 1'b0;
    if (alt_set) begin
      case (code) inside
        FC_READ_COILS, FC_READ_HOLDING, FC_WRITE_COIL,
        FC_WRITE_REGISTER, FC_DIAGNOSTICS: ok = 1'b1;
        default:                            ok = 1'b0;
      endcase
    end else begin
      case (code) inside
        FC_READ_HOLDING, FC_READ_INPUT,
        FC_WRITE_REGISTER, FC_DIAGNOSTICS: ok = 1'b1;
        default:                            ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

@@ src/rfr_in_reg.sv @@
// Input register stage: captures one word and holds it until the frame logic takes it.
// Depends on rfr_pkg.
module rfr_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rfr_pkg::rfr_in_t word_i,
  input  logic            take_i,
  output logic            valid_o,
  output rfr_pkg::rfr_in_t word_o
);

  logic             valid_q;
  rfr_pkg::rfr_in_t word_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_i;
    end
  end

endmodule

@@ src/rfr_frame.sv @@
// Frame assembly: position, gap timer, running CRC and stored frame bytes.
// Processes one word per take; depends on rfr_pkg.
module rfr_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  rfr_pkg::rfr_in_t  word_i,
  input  rfr_pkg::rfr_cfg_t cfg_i,
  output logic              res_valid_o,
  output rfr_pkg::rfr_out_t res_o
);

  logic [rfr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                gap_q, gap_d;
  logic [15:0]               crc_q, crc_d;
  logic [7:0]                bytes_q [1:rfr_pkg::FRAME_LENGTH-2];
  logic                      store_byte;
  logic                      crc_ok;
  logic [7:0]                reload;

  assign reload = rfr_pkg::gap_reload(cfg_i.gap_ticks);
  assign crc_ok = (bytes_q[rfr_pkg::FRAME_LENGTH-2] == crc_q[7:0]) &&
                  (word_i.rx_byte == crc_q[15:8]);

  always_comb begin
    pos_d       = pos_q;
    gap_d       = gap_q;
    crc_d       = crc_q;
    store_byte  = 1'b0;
    res_valid_o = 1'b0;

    res_o.status           = crc_ok ?
        (rfr_pkg::is_supported(bytes_q[1], cfg_i.alt_function_set) ?
         rfr_pkg::STATUS_SUPPORTED : rfr_pkg::STATUS_UNSUPPORTED) :
        rfr_pkg::STATUS_CRC_ERROR;
    res_o.function_code    = bytes_q[1];
    res_o.first_word_high  = bytes_q[2];
    res_o.first_word_low   = bytes_q[3];
    res_o.second_word_high = bytes_q[4];
    res_o.second_word_low  = bytes_q[5];

    if (word_i.kind == rfr_pkg::KIND_TICK) begin
      if (gap_q != 8'd0) begin
        gap_d = gap_q - 8'd1;
        if (gap_q == 8'd1) begin
          pos_d = rfr_pkg::POS_IDLE;
        end
      end
    end else if (pos_q == rfr_pkg::POS_IDLE) begin
      gap_d = reload;
      if (word_i.rx_byte == cfg_i.station_id && gap_q == 8'd0) begin
        crc_d = rfr_pkg::crc_byte(rfr_pkg::CRC_INIT, word_i.rx_byte);
        pos_d = rfr_pkg::POS_FIRST;
      end
    end else if (pos_q < rfr_pkg::POS_LAST) begin
      gap_d      = reload;
      store_byte = 1'b1;
      if (pos_q < rfr_pkg::POS_CRC_LO) begin
        crc_d = rfr_pkg::crc_byte(crc_q, word_i.rx_byte);
      end
      pos_d = pos_q + rfr_pkg::POS_W'(1);
    end else if (pos_q == rfr_pkg::POS_LAST) begin
      gap_d       = reload;
      res_valid_o = 1'b1;
      pos_d       = crc_ok ? rfr_pkg::POS_DONE : rfr_pkg::POS_IDLE;
    end
    // done: bytes ignored until the gap expires

    if (!take_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= rfr_pkg::POS_IDLE;
      gap_q <= 8'd0;
      crc_q <= rfr_pkg::CRC_INIT;
    end else if (take_i) begin
      pos_q <= pos_d;
      gap_q <= gap_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && store_byte) begin
      bytes_q[pos_q[rfr_pkg::BYTE_IDX_W-1:0]] <= word_i.rx_byte;
    end
  end

endmodule

@@ src/rfr_out_reg.sv @@
// Result register: holds one result word until the consumer takes it.
// Depends on rfr_pkg.
module rfr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rfr_pkg::rfr_out_t word_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output rfr_pkg::rfr_out_t word_o
);

  logic              valid_q;
  rfr_pkg::rfr_out_t word_q;

  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

endmodule

@@ src/rtu_request_frame_receiver_core.sv @@
// Modbus RTU request frame receiver, top level. Uses rfr_pkg, rfr_in_reg,
// rfr_frame and rfr_out_reg.
//
// Takes a stream of words, each either one received serial byte or one timer
// tick, and assembles fixed 8-byte requests. Bytes not ignored reload a gap timer
// with gap_ticks (0 acts as 1); ticks count it down and expiry returns the
// frame to its start. A frame starts on a byte equal to station_id while the
// gap timer has run out. CRC-16/MODBUS runs over bytes 0..5, bytes 6 and 7
// must carry its low and high halves. The eighth byte yields one result word:
// status (supported, unsupported function, or CRC error) plus bytes 1..5.
// After a good frame further bytes are ignored until the gap expires.
// Rate: one word per clock while no result waits unread. A word is latched
// in the input register, then the frame logic (one 8-step CRC byte update)
// runs combinationally into the result register, loaded when the word is
// taken. Input stalls only while a result waits unread.
// Config: plain write port, index 0 station_id, 1 gap_ticks, 2
// alt_function_set; other indexes are dropped. Write only while idle.
module rtu_request_frame_receiver_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rfr_pkg::rfr_in_t                   in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rfr_pkg::rfr_out_t                  out_word_o,
  input  logic                               cfg_we_i,
  input  logic [rfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [7:0]                         cfg_wdata_i
);

  rfr_pkg::rfr_cfg_t cfg_q;
  logic              item_valid;
  rfr_pkg::rfr_in_t  item;
  logic              out_space;
  logic              take;
  logic              res_valid;
  rfr_pkg::rfr_out_t res;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_id       <= 8'd1;
      cfg_q.gap_ticks        <= 8'd3;
      cfg_q.alt_function_set <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rfr_pkg::REG_STATION_ID: cfg_q.station_id       <= cfg_wdata_i;
        rfr_pkg::REG_GAP_TICKS:  cfg_q.gap_ticks        <= cfg_wdata_i;
        rfr_pkg::REG_ALT_SET:    cfg_q.alt_function_set <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // a word is processed whenever the result register can take whatever it yields
  assign take = item_valid && out_space;

  rfr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .word_i  (in_word_i),
    .take_i  (take),
    .valid_o (item_valid),
    .word_o  (item)
  );

  rfr_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (item),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rfr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .word_i  (res),
    .space_o (out_space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .word_o  (out_word_o)
  );

endmodule

@@ src/rfr_checker.sv @@
// Port-level checks for the frame receiver, bound to the top level.
// Depends on rfr_pkg and rtu_request_frame_receiver_core.
module rfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input rfr_pkg::rfr_out_t             out_word_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // input only backs up behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // results are a frame apart, never back to back
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("two results in consecutive cycles");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> out_word_o.status == rfr_pkg::STATUS_SUPPORTED ||
                      out_word_o.status == rfr_pkg::STATUS_UNSUPPORTED ||
                      out_word_o.status == rfr_pkg::STATUS_CRC_ERROR)
    else $error("undefined status code");

endmodule

bind rtu_request_frame_receiver_core rfr_checker u_rfr_checker (.*);

@@ tb/rtu_request_frame_receiver_core_tb.sv @@
// Self-checking testbench for rtu_request_frame_receiver_core: directed table, then
// random request traffic over several register settings, checked word by word.
// Depends on rfr_pkg and the core RTL only.
module rtu_request_frame_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfr_pkg::*;

  // cycles with no handshake and no register write before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // bound on waiting for outstanding results before a register write or the end
  localparam int DRAIN_LIMIT    = 1000;
  // input register plus frame stage, with some margin for words
  // that produce no result but may still be in flight
  localparam int PIPE_SLACK     = 4;
  // receiver back-pressure long enough to fill the block and stall its input
  localparam int LONG_HOLD      = 300;
  // index past the end of the register list; the block must drop it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ROW_BYTE,     // plain received byte
    ROW_TICK,     // timer tick, payload is don't-care
    ROW_CRC_LO,   // running CRC low half, xor value as corruption mask
    ROW_CRC_HI,   // running CRC high half, xor value as corruption mask
    ROW_CFG       // register write, value goes to reg_idx
  } row_op_e;

  typedef struct {
    row_op_e                op;
    logic [7:0]             value;
    logic [CFG_IDX_W-1:0]   reg_idx;
    bit                     has_result;   // result typed into the table
    rfr_out_t               result;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  rfr_in_t                in_word_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  rfr_out_t               out_word_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [7:0]             cfg_wdata_i;

  rtu_request_frame_receiver_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: register copies and assembly state, advanced once per
  // accepted input word.
  // ---------------------------------------------------------------------------
  logic [7:0]        cfg_station;
  logic [7:0]        cfg_gap;
  logic              cfg_alt;
  logic [POS_W-1:0]  frame_pos;
  logic [7:0]        frame_store [FRAME_LENGTH-1];
  logic [15:0]       frame_crc;
  logic [7:0]        gap_left;

  rfr_out_t          pending_requests [$];   // decoded requests still owed by the block
  stim_row_t         directed_rows [$];
  int                error_count = 0;
  int                words_sent  = 0;
  int                send_mode   = 1;        // 0: back-to-back words, 1: random gaps
  bit                hold_requested = 1'b0;  // asks the receiver for one long hold-off

  // CRC-16/MODBUS, reflected: feed one data bit per step into the feedback
  function automatic logic [15:0] fold_crc(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[15:1]};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic code_accepted(input logic [7:0] code, input logic alt);
    return alt ? (code inside {FC_READ_COILS, FC_READ_HOLDING, FC_WRITE_COIL,
                               FC_WRITE_REGISTER, FC_DIAGNOSTICS})
               : (code inside {FC_READ_HOLDING, FC_READ_INPUT,
                               FC_WRITE_REGISTER, FC_DIAGNOSTICS});
  endfunction

  task automatic frame_step(input rfr_in_t w, output bit produced, output rfr_out_t res);
    logic [7:0] reload;
    bit         crc_ok;
    reload   = (cfg_gap == 8'd0) ? 8'd1 : cfg_gap;   // zero gap acts as one tick
    produced = 1'b0;
    res      = '0;
    if (w.kind == KIND_TICK) begin
      // expiry drops any partial or finished frame; an expired timer stays put
      if (gap_left != 8'd0) begin
        gap_left = gap_left - 8'd1;
        if (gap_left == 8'd0) frame_pos = POS_IDLE;
      end
    end else if (frame_pos == POS_IDLE) begin
      // start needs our address and a quiet line; either way the timer reloads
      if (w.rx_byte == cfg_station && gap_left == 8'd0) begin
        frame_store[0] = w.rx_byte;
        frame_crc      = fold_crc(CRC_INIT, w.rx_byte);
        frame_pos      = POS_FIRST;
      end
      gap_left = reload;
    end else if (frame_pos < POS_LAST) begin
      frame_store[frame_pos] = w.rx_byte;
      if (frame_pos < POS_CRC_LO) frame_crc = fold_crc(frame_crc, w.rx_byte);
      frame_pos = frame_pos + 1'b1;
      gap_left  = reload;
    end else if (frame_pos == POS_LAST) begin
      crc_ok = (frame_store[POS_CRC_LO] == frame_crc[7:0]) && (w.rx_byte == frame_crc[15:8]);
      if (!crc_ok)                                    res.status = STATUS_CRC_ERROR;
      else if (code_accepted(frame_store[1], cfg_alt)) res.status = STATUS_SUPPORTED;
      else                                            res.status = STATUS_UNSUPPORTED;
      res.function_code    = frame_store[1];
      res.first_word_high  = frame_store[2];
      res.first_word_low   = frame_store[3];
      res.second_word_high = frame_store[4];
      res.second_word_low  = frame_store[5];
      frame_pos = crc_ok ? POS_DONE : POS_IDLE;
      gap_left  = reload;
      produced  = 1'b1;
    end
    // POS_DONE: bytes are dropped without touching the timer
  endtask

  // ---------------------------------------------------------------------------
  // Reporting and pacing
  // ---------------------------------------------------------------------------
  task automatic report_error(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s got %02h expected %02h", name, got, want));
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input int mode);
    int unsigned r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_function();
    case ($urandom_range(0, 9))
      0:       return FC_READ_COILS;
      1:       return FC_READ_HOLDING;
      2:       return FC_READ_INPUT;
      3:       return FC_WRITE_COIL;
      4:       return FC_WRITE_REGISTER;
      5:       return FC_DIAGNOSTICS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Tasks are entered right after a rising edge; valid and
  // payload are driven with NBAs and held until the word is taken.
  // ---------------------------------------------------------------------------
  task automatic offer_word(input logic kind, input logic [7:0] value,
                            output bit produced, output rfr_out_t res);
    int unsigned gap;
    rfr_in_t     w;
    gap       = pick_gap(send_mode);
    w.kind    = kind;
    w.rx_byte = value;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    // ready sampled here is the value the block saw at this edge
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    frame_step(w, produced, res);
  endtask

  task automatic send_word(input logic kind, input logic [7:0] value);
    bit       produced;
    rfr_out_t res;
    offer_word(kind, value, produced, res);
    if (produced) pending_requests.push_back(res);
    words_sent++;
  endtask

  // stop offering, let owed results come back, then let the pipe empty
  task automatic settle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_requests.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // one register write per edge; the caller drops the write enable afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_STATION_ID: cfg_station = value;
      REG_GAP_TICKS:  cfg_gap     = value;
      REG_ALT_SET:    cfg_alt     = value[0];
      default:        ;
    endcase
  endtask

  task automatic add_row(input row_op_e op, input logic [7:0] value,
                         input logic [CFG_IDX_W-1:0] idx = '0,
                         input bit has_result = 1'b0, input rfr_out_t result = '0);
    stim_row_t row;
    row.op         = op;
    row.value      = value;
    row.reg_idx    = idx;
    row.has_result = has_result;
    row.result     = result;
    directed_rows.push_back(row);
  endtask

  // Random traffic: mostly well-formed requests with random content (line
  // goes quiet first, address matches, CRC right), the rest refused starts,
  // corrupted CRC halves, cut-off frames, trailing bytes and plain noise.
  task automatic run_traffic(input int budget);
    int          stop_at;
    int          r;
    int          n;
    logic [7:0]  lo_mask;
    logic [7:0]  hi_mask;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      send_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      r = $urandom_range(0, 99);
      if (r < 85) begin
        // run the timer out; now and then one tick short so the start is refused
        n = gap_left;
        if (n > 0 && $urandom_range(0, 9) == 0) n--;
        else if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 2);
        repeat (n) send_word(KIND_TICK, 8'($urandom_range(0, 255)));
        send_word(KIND_BYTE, ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                            : cfg_station);
        if (r < 70) begin
          send_word(KIND_BYTE, pick_function());
          repeat (4) send_word(KIND_BYTE, pick_data());
          // a tick inside the frame only matters when the gap is one tick
          if ($urandom_range(0, 19) == 0) send_word(KIND_TICK, 8'($urandom_range(0, 255)));
          lo_mask = 8'h00;
          hi_mask = 8'h00;
          case ($urandom_range(0, 9))
            0: lo_mask = 8'($urandom_range(1, 255));
            1: hi_mask = 8'($urandom_range(1, 255));
            2: begin
              lo_mask = 8'($urandom_range(1, 255));
              hi_mask = 8'($urandom_range(1, 255));
            end
            default: ;
          endcase
          send_word(KIND_BYTE, frame_crc[7:0] ^ lo_mask);
          send_word(KIND_BYTE, frame_crc[15:8] ^ hi_mask);
          // trailing bytes: dropped after a good frame, restart logic otherwise
          if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        end else begin
          // cut-off frame; the next expiry throws it away
          repeat ($urandom_range(1, 6)) send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // registers change only with the block idle; the unused index is written too
  task automatic run_phase(input logic [7:0] station, input logic [7:0] gap,
                           input logic [7:0] alt_word, input int budget, input bit hold);
    settle();
    write_reg(REG_STATION_ID, station);
    write_reg(REG_GAP_TICKS, gap);
    write_reg(REG_ALT_SET, alt_word);
    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
    if (hold) hold_requested = 1'b1;
    run_traffic(budget);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: ready with random stalls under a periodically re-picked mode
  // (0 = always ready), plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_left;
    int cycles_in_mode;
    int recv_mode;
    out_ready_i    = 1'b0;
    stall_left     = 0;
    hold_left      = 0;
    cycles_in_mode = 0;
    recv_mode      = 1;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (cycles_in_mode == 0) begin
        recv_mode      = $urandom_range(0, 2);
        cycles_in_mode = 64;
      end
      cycles_in_mode--;
      if (hold_requested) begin
        hold_requested = 1'b0;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (recv_mode != 0 && $urandom_range(0, 99) < ((recv_mode == 2) ? 40 : 10))
          stall_left = pick_gap(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each taken result word against the oldest owed request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    rfr_out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_requests.size() == 0) begin
        report_error($sformatf("result word with none owed, function code %02h",
                               out_word_o.function_code));
      end else begin
        want = pending_requests.pop_front();
        check_field("status", 8'(out_word_o.status), 8'(want.status));
        check_field("function_code", out_word_o.function_code, want.function_code);
        check_field("first_word_high", out_word_o.first_word_high, want.first_word_high);
        check_field("first_word_low", out_word_o.first_word_low, want.first_word_low);
        check_field("second_word_high", out_word_o.second_word_high, want.second_word_high);
        check_field("second_word_low", out_word_o.second_word_low, want.second_word_low);
      end
    end
  end

  // ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready_i === 1'b1) || cfg_we_i === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   row;
    logic        kind;
    logic [7:0]  value;
    bit          produced;
    rfr_out_t    got;
    bit          cfg_open;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    cfg_open    = 1'b0;

    // predictor mirrors the reset state
    cfg_station = 8'd1;
    cfg_gap     = 8'd3;
    cfg_alt     = 1'b0;
    frame_pos   = POS_IDLE;
    frame_crc   = CRC_INIT;
    gap_left    = 8'd0;
    foreach (frame_store[i]) frame_store[i] = 8'h00;

    // Directed table. Reset settings first: station 1, gap 3, base function set.
    // Good read-holding request straight out of reset (line counts as quiet).
    add_row(ROW_BYTE, 8'h01);
    add_row(ROW_BYTE, FC_READ_HOLDING);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_BYTE, 8'h01);
    add_row(ROW_CRC_LO, 8'h00);
    add_row(ROW_CRC_HI, 8'h00);
    // finished frame: this byte is dropped and does not reload the timer
    add_row(ROW_BYTE, 8'hFF);
    // three ticks expire the gap, the fourth finds it already expired
    add_row(ROW_TICK, 8'h00);
    add_row(ROW_TICK, 8'hFF);
    add_row(ROW_TICK, 8'h00);
    add_row(ROW_TICK, 8'hFF);
    // station 255, zero gap (acts as one), alt set via bit 0 only, unused index
    add_row(ROW_CFG, 8'hFF, REG_STATION_ID);
    add_row(ROW_CFG, 8'h00, REG_GAP_TICKS);
    add_row(ROW_CFG, 8'hFF, REG_ALT_SET);
    add_row(ROW_CFG, 8'h5A, REG_UNUSED);
    // wrong address on a quiet line: no start, timer reloads to one
    add_row(ROW_BYTE, 8'h02);
    add_row(ROW_TICK, 8'h00);
    // high CRC half corrupted: CRC error carries the received bytes
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_BYTE, FC_READ_INPUT);
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_BYTE, 8'h80);
    add_row(ROW_BYTE, 8'h01);
    add_row(ROW_CRC_LO, 8'h00);
    add_row(ROW_CRC_HI, 8'h80, '0, 1'b1,
            rfr_out_t'{STATUS_CRC_ERROR, FC_READ_INPUT, 8'hFF, 8'h00, 8'h80, 8'h01});
    // right address but the timer was reloaded by the error: no start
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_TICK, 8'h00);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(row.reg_idx, row.value);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        kind = KIND_BYTE;
        case (row.op)
          ROW_TICK: begin
            kind  = KIND_TICK;
            value = 8'($urandom_range(0, 255));
          end
          ROW_CRC_LO: value = frame_crc[7:0] ^ row.value;
          ROW_CRC_HI: value = frame_crc[15:8] ^ row.value;
          default:    value = row.value;
        endcase
        offer_word(kind, value, produced, got);
        words_sent++;
        if (produced) pending_requests.push_back(row.has_result ? row.result : got);
      end
    end

    // random phases; register extremes on the first two, wide gap last and
    // given more words since its ticks eat most of them
    run_phase(8'h00, 8'd1, 8'h00, 110, 1'b0);
    run_phase(8'hFF, 8'd0, 8'h01, 110, 1'b1);   // long receiver hold-off here
    run_phase(8'($urandom_range(1, 254)), 8'd2, 8'hFE, 110, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'd3, 8'h01, 110, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'hFF, 8'($urandom_range(0, 255)), 290, 1'b0);

    settle();
    if (pending_requests.size() != 0)
      report_error($sformatf("%0d result words never arrived", pending_requests.size()));

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
